FILE: hdl/ipc_pkg.sv
// shared types, constants and key codes of the irrigation pump controller
package ipc_pkg;

  // entry digits and derived count width
  localparam int unsigned ENTRY_DIGITS = 2;
  localparam int unsigned CNT_W        = $clog2(ENTRY_DIGITS + 1);

  localparam logic [6:0] TARGET_MAX = 7'd99;

  // field widths
  localparam int unsigned KEY_W   = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned LIGHT_W = 10;
  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned IVL_W   = 16;
  localparam int unsigned MAXP_W  = 24;
  localparam int unsigned BONUS_W = 6;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CIDX_W  = 3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SENSOR_INTERVAL = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_PUMP        = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_HEAT_LIMIT      = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_HEAT_BONUS      = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_LIGHT_LIMIT     = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_FREEZE_LIMIT    = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_START_THRESHOLD = 3'd6;

  // reset values of the configuration registers
  localparam logic [IVL_W-1:0]          RST_INTERVAL  = 16'd1000;
  localparam logic [MAXP_W-1:0]         RST_MAX_PUMP  = 24'd60000;
  localparam logic signed [TEMP_W-1:0]  RST_HEAT      = 12'sd350;
  localparam logic [BONUS_W-1:0]        RST_BONUS     = 6'd10;
  localparam logic [LIGHT_W-1:0]        RST_LIGHT     = 10'd800;
  localparam logic signed [TEMP_W-1:0]  RST_FREEZE    = 12'sd20;
  localparam logic [PCT_W-1:0]          RST_THRESHOLD = 7'd40;

  // key codes
  localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;
  localparam logic [KEY_W-1:0] KEY_A    = 8'h41;
  localparam logic [KEY_W-1:0] KEY_B    = 8'h42;
  localparam logic [KEY_W-1:0] KEY_C    = 8'h43;
  localparam logic [KEY_W-1:0] KEY_STAR = 8'h2A;
  localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;
  localparam logic [KEY_W-1:0] KEY_ZERO = 8'h30;
  localparam logic [KEY_W-1:0] KEY_NINE = 8'h39;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SENSE = 2'd1,
    PH_WATER = 2'd2,
    PH_ENTRY = 2'd3
  } phase_t;

  typedef logic [KEY_W-1:0]          key_t;
  typedef logic [TIME_W-1:0]         time_t;
  typedef logic [PCT_W-1:0]          pct_t;
  typedef logic [LIGHT_W-1:0]        light_t;
  typedef logic signed [TEMP_W-1:0]  temp_t;

  function automatic pct_t sat_target(input logic [9:0] v);
    if (v > 10'(TARGET_MAX)) begin
      return TARGET_MAX;
    end
    return v[PCT_W-1:0];
  endfunction

endpackage

FILE: hdl/ipc_in_if.sv
// input channel: one control loop pass per transaction
interface ipc_in_if;
  logic               valid;
  logic               ready;
  ipc_pkg::key_t      key_code;
  ipc_pkg::time_t     now_ms;
  ipc_pkg::pct_t      moisture_pct;
  ipc_pkg::light_t    light_raw;
  ipc_pkg::temp_t     temp_tenths;

  modport source (output valid, key_code, now_ms, moisture_pct, light_raw, temp_tenths,
                  input ready);
  modport sink   (input valid, key_code, now_ms, moisture_pct, light_raw, temp_tenths,
                  output ready);
endinterface

FILE: hdl/ipc_out_if.sv
// result channel: pump and status per transaction
interface ipc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       pump_on;
  logic [1:0]                 phase;
  logic                       locked;
  logic                       auto_mode;
  ipc_pkg::pct_t              moisture_target;
  ipc_pkg::pct_t              entry_value;
  logic [1:0]                 entry_count;

  modport source (output valid, pump_on, phase, locked, auto_mode, moisture_target,
                  entry_value, entry_count, input ready);
  modport sink   (input valid, pump_on, phase, locked, auto_mode, moisture_target,
                  entry_value, entry_count, output ready);
endinterface

FILE: hdl/irrigation_pump_controller_top.sv
// irrigation pump controller: key handling, phase machine and result register
//
//  channel   | direction | contents
//  in_ch     | sink      | key_code, now_ms, moisture_pct, light_raw, temp_tenths
//  out_ch    | source    | pump_on, phase, locked, auto_mode, moisture_target,
//            |           | entry_value, entry_count
//  cfg_*     | write     | cfg_we, cfg_index, cfg_wdata
//
// one transaction per cycle sustained while results are taken; path from input to result:
// input register, then state update and result register in one pass
// rst_n is synchronous, active low; state and configuration take their reset values
// a stalled result holds the result register; the input register still takes a
// transaction whenever it is empty or moving on
module irrigation_pump_controller_top (
  input  logic                         clk,
  input  logic                         rst_n,
  ipc_in_if.sink                       in_ch,
  ipc_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [ipc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [ipc_pkg::CFG_W-1:0]    cfg_wdata
);
  import ipc_pkg::*;

  // configuration
  logic [IVL_W-1:0]   interval_r;
  logic [MAXP_W-1:0]  max_pump_r;
  temp_t              heat_limit_r;
  logic [BONUS_W-1:0] heat_bonus_r;
  light_t             light_limit_r;
  temp_t              freeze_limit_r;

  // input register
  logic   in_v_r;
  key_t   key_r;
  time_t  now_r;
  pct_t   moist_r;
  light_t light_r;
  temp_t  temp_r;

  // controller state
  phase_t           phase_r, phase_nxt;
  logic             pump_r, pump_nxt;
  logic             lock_r, lock_nxt;
  logic             auto_r, auto_nxt;
  pct_t             target_r, target_nxt;
  pct_t             entry_value_r, entry_value_nxt;
  logic [CNT_W-1:0] entry_count_r, entry_count_nxt;
  time_t            last_read_r, last_read_nxt;
  time_t            pump_start_r, pump_start_nxt;

  // result register
  logic       out_v_r;
  logic       res_pump_r;
  logic [1:0] res_phase_r;
  logic       res_lock_r;
  logic       res_auto_r;
  pct_t       res_target_r;
  pct_t       res_value_r;
  logic [1:0] res_count_r;
  logic [1:0] res_count_nxt;
  logic [2:0] cnt_ext;

  logic       advance;
  logic       fire;
  time_t      since_read;
  time_t      since_pump;
  logic [3:0] digit;
  logic [9:0] entry_sum;
  logic [7:0] thr;
  logic       start_pump;

  assign advance     = !out_v_r || out_ch.ready;
  assign in_ch.ready = !in_v_r || advance;
  assign fire        = in_v_r && advance;

  assign since_read = now_r - last_read_r;
  assign since_pump = now_r - pump_start_r;
  assign digit      = 4'(key_r - KEY_ZERO);
  assign entry_sum  = 10'(entry_value_r) * 10'd10 + 10'(digit);

  // next state: keys first, then the phase machine on the phase they leave
  always_comb begin
    phase_nxt       = phase_r;
    pump_nxt        = pump_r;
    lock_nxt        = lock_r;
    auto_nxt        = auto_r;
    target_nxt      = target_r;
    entry_value_nxt = entry_value_r;
    entry_count_nxt = entry_count_r;
    last_read_nxt   = last_read_r;
    pump_start_nxt  = pump_start_r;
    thr             = '0;
    start_pump      = 1'b0;

    if (key_r != KEY_NONE) begin
      if (key_r == KEY_A) begin
        auto_nxt = 1'b1;
      end
      if (key_r == KEY_B) begin
        auto_nxt  = 1'b0;
        pump_nxt  = 1'b0;
        phase_nxt = PH_IDLE;
      end
      if (key_r == KEY_C && lock_r) begin
        lock_nxt  = 1'b0;
        phase_nxt = PH_IDLE;
      end
      if (key_r == KEY_STAR) begin
        phase_nxt       = PH_ENTRY;
        entry_value_nxt = '0;
        entry_count_nxt = '0;
      end else if (key_r == KEY_HASH) begin
        if (phase_nxt == PH_ENTRY && entry_count_r != '0) begin
          target_nxt = entry_value_r;
        end
        phase_nxt = PH_IDLE;
      end else if (phase_nxt == PH_ENTRY) begin
        if (key_r >= KEY_ZERO && key_r <= KEY_NINE &&
            32'(entry_count_r) < ENTRY_DIGITS) begin
          entry_value_nxt = sat_target(entry_sum);
          entry_count_nxt = entry_count_r + 1'b1;
        end
      end
    end

    unique case (phase_nxt)
      PH_IDLE: begin
        if (since_read >= 32'(interval_r)) begin
          phase_nxt = PH_SENSE;
        end
      end
      PH_SENSE: begin
        last_read_nxt = now_r;
        if (auto_nxt && !lock_nxt) begin
          thr = 8'(target_nxt);
          if (temp_r > heat_limit_r) begin
            thr = 8'(target_nxt) + 8'(heat_bonus_r);
          end
          start_pump = (8'(moist_r) < thr) && !(light_r > light_limit_r) &&
                       !(temp_r < freeze_limit_r);
        end
        if (start_pump) begin
          pump_nxt       = 1'b1;
          pump_start_nxt = now_r;
          phase_nxt      = PH_WATER;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_WATER: begin
        if (since_pump > 32'(max_pump_r)) begin
          pump_nxt  = 1'b0;
          lock_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
        end else if (since_read >= 32'(interval_r)) begin
          last_read_nxt = now_r;
          if (moist_r >= target_nxt) begin
            pump_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_ENTRY: begin
      end
    endcase
  end

  // result fields; the count shown saturates at three
  always_comb begin
    cnt_ext       = 3'(entry_count_nxt);
    res_count_nxt = (cnt_ext > 3'd3) ? 2'd3 : cnt_ext[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      key_r   <= in_ch.key_code;
      now_r   <= in_ch.now_ms;
      moist_r <= in_ch.moisture_pct;
      light_r <= in_ch.light_raw;
      temp_r  <= in_ch.temp_tenths;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r     <= RST_INTERVAL;
      max_pump_r     <= RST_MAX_PUMP;
      heat_limit_r   <= RST_HEAT;
      heat_bonus_r   <= RST_BONUS;
      light_limit_r  <= RST_LIGHT;
      freeze_limit_r <= RST_FREEZE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SENSOR_INTERVAL: interval_r     <= cfg_wdata[IVL_W-1:0];
        CFG_MAX_PUMP:        max_pump_r     <= cfg_wdata[MAXP_W-1:0];
        CFG_HEAT_LIMIT:      heat_limit_r   <= temp_t'(cfg_wdata[TEMP_W-1:0]);
        CFG_HEAT_BONUS:      heat_bonus_r   <= cfg_wdata[BONUS_W-1:0];
        CFG_LIGHT_LIMIT:     light_limit_r  <= cfg_wdata[LIGHT_W-1:0];
        CFG_FREEZE_LIMIT:    freeze_limit_r <= temp_t'(cfg_wdata[TEMP_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      pump_r        <= 1'b0;
      lock_r        <= 1'b0;
      auto_r        <= 1'b1;
      target_r      <= sat_target(10'(RST_THRESHOLD));
      entry_value_r <= '0;
      entry_count_r <= '0;
      last_read_r   <= '0;
      pump_start_r  <= '0;
    end else begin
      if (fire) begin
        phase_r       <= phase_nxt;
        pump_r        <= pump_nxt;
        lock_r        <= lock_nxt;
        auto_r        <= auto_nxt;
        target_r      <= target_nxt;
        entry_value_r <= entry_value_nxt;
        entry_count_r <= entry_count_nxt;
        last_read_r   <= last_read_nxt;
        pump_start_r  <= pump_start_nxt;
      end
      // threshold write reloads the target; issue it only while no transaction is in flight (block does not enforce)
      if (cfg_we && cfg_index == CFG_START_THRESHOLD) begin
        target_r <= sat_target(10'(cfg_wdata[PCT_W-1:0]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_pump_r   <= pump_nxt;
      res_phase_r  <= phase_nxt;
      res_lock_r   <= lock_nxt;
      res_auto_r   <= auto_nxt;
      res_target_r <= target_nxt;
      res_value_r  <= entry_value_nxt;
      res_count_r  <= res_count_nxt;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.pump_on         = res_pump_r;
  assign out_ch.phase           = res_phase_r;
  assign out_ch.locked          = res_lock_r;
  assign out_ch.auto_mode       = res_auto_r;
  assign out_ch.moisture_target = res_target_r;
  assign out_ch.entry_value     = res_value_r;
  assign out_ch.entry_count     = res_count_r;

  // the lock is only set by a timeout that also stops the pump, and nothing restarts it while locked
  a_lock_stops_pump: assert property (@(posedge clk) disable iff (!rst_n)
    lock_r |-> !pump_r)
    else $error("pump running while safety lock is set");

  a_water_has_pump: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WATER) |-> pump_r)
    else $error("watering phase with pump off");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(entry_count_r) <= ENTRY_DIGITS)
    else $error("entry digit count beyond limit");

  a_target_bound: assert property (@(posedge clk) disable iff (!rst_n)
    target_r <= TARGET_MAX)
    else $error("moisture target above saturation");

  a_result_follows_pass: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_v_r && res_phase_r == phase_r && res_pump_r == pump_r)
    else $error("result register out of step with controller state");

endmodule
